FILE: hdl/llmsr_pkg.sv
// llmsr_pkg: shared widths, defaults and operation codes for the box list block
// no dependencies
`timescale 1ns / 1ps

package llmsr_pkg;

	localparam int BOX_W         = 11;
	localparam int OP_W          = 3;
	localparam int SUM_W         = 20;
	localparam int MAX_BOXES_DEF = 1024;
	localparam int BOX_COUNT_RST = 1024;

	localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
	localparam logic [OP_W-1:0] OP_LEFT    = 3'd1;
	localparam logic [OP_W-1:0] OP_RIGHT   = 3'd2;
	localparam logic [OP_W-1:0] OP_SWAP    = 3'd3;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

endpackage

FILE: hdl/llmsr_ram.sv
// llmsr_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module llmsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/linked_list_move_swap_reverse.sv
// linked_list_move_swap_reverse: circular doubly linked box list with lazy reverse
// uses llmsr_pkg and two llmsr_ram instances (next links, previous links)
//
// channel   dir  fields (low bit up)                               handshake
// s_axis    in   tdata: operation[2:0] box_a[13:3] box_b[24:14]     tvalid/tready
// m_axis    out  tdata: odd_position_sum[19:0]                      tvalid/tready
// cfg       in   cfg_wdata: box_count[10:0]                         cfg_we
//
// reverse, ignored and rejected items finish in idle; moves and swaps first take two link
// reads through the one read port of each ram, then write their joins in turn (three, or four
// for a swap of boxes that are not neighbours); a move already in place writes none
// init: one table entry written per cycle
// query: one link followed per cycle through the next-link ram read port
// reset clears control state only; link tables hold garbage until the first init
// a query result waits in the output register; the query end holds if it is still full
`timescale 1ns / 1ps

module linked_list_move_swap_reverse #(
	parameter int MAX_BOXES = llmsr_pkg::MAX_BOXES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // operation, box_a, box_b, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // odd_position_sum, zero pad
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata  // box_count
);

	localparam int IW    = $clog2(MAX_BOXES + 1);
	localparam int DEPTH = MAX_BOXES + 1;
	localparam int CW    = (IW > llmsr_pkg::BOX_W) ? IW : llmsr_pkg::BOX_W;
	localparam int SW    = llmsr_pkg::SUM_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDA  = 4'd1;
	localparam logic [3:0] ST_RDB  = 4'd2;
	localparam logic [3:0] ST_EVAL = 4'd3;
	localparam logic [3:0] ST_WR   = 4'd4;
	localparam logic [3:0] ST_INIT = 4'd5;
	localparam logic [3:0] ST_Q0   = 4'd6;
	localparam logic [3:0] ST_QW   = 4'd7;
	localparam logic [3:0] ST_QFIN = 4'd8;

	logic [3:0]                     state_q;
	logic [llmsr_pkg::BOX_W-1:0]    box_count_q;
	logic                           rev_q;
	logic                           ready_q;
	logic [IW-1:0]                  size_q;
	logic [llmsr_pkg::OP_W-1:0]     op_q;
	logic [IW-1:0]                  a_q, b_q, la_q, ra_q;
	logic [IW-1:0]                  jl_q [4];
	logic [IW-1:0]                  jr_q [4];
	logic [1:0]                     jlast_q, k_q;
	logic [IW-1:0]                  iter_q;
	logic [SW-1:0]                  sum_q, tri_q;
	logic                           m_tvalid_q;
	logic [SW-1:0]                  res_q;

	// ram ports
	logic          nxt_we, prv_we;
	logic [IW-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
	logic [IW-1:0] nxt_raddr, prv_raddr, nxt_rdata, prv_rdata;

	// decode of the incoming item
	logic [llmsr_pkg::OP_W-1:0]  in_op;
	logic [llmsr_pkg::BOX_W-1:0] in_a, in_b;
	logic [CW-1:0]               in_a_w, in_b_w, size_w, cnt_w, n_init_w;
	logic                        mv_ok;

	assign in_op  = s_tdata[2:0];
	assign in_a   = s_tdata[13:3];
	assign in_b   = s_tdata[24:14];
	assign in_a_w = CW'(in_a);
	assign in_b_w = CW'(in_b);
	assign size_w = CW'(size_q);
	assign cnt_w  = CW'(box_count_q);
	assign mv_ok  = (in_a_w != '0) && (in_b_w != '0) && (in_a_w <= size_w)
		&& (in_b_w <= size_w) && (in_a != in_b);

	// box_count clamped to 1..MAX_BOXES
	always_comb begin
		priority if (cnt_w == '0) begin
			n_init_w = CW'(1);
		end else if (cnt_w > CW'(MAX_BOXES)) begin
			n_init_w = CW'(MAX_BOXES);
		end else begin
			n_init_w = cnt_w;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// evaluation of a move once both boxes' links are in
	logic [IW-1:0]              rb, lb, ea, eb, ela, era, elb, erb, cur;
	logic                       do_swap, skip;
	logic [llmsr_pkg::OP_W-1:0] eop;
	logic [IW-1:0]              ejl [4];
	logic [IW-1:0]              ejr [4];
	logic [1:0]                 elast;

	assign rb      = nxt_rdata;
	assign lb      = prv_rdata;
	assign do_swap = (op_q == llmsr_pkg::OP_SWAP) && (rb == a_q);

	always_comb begin
		ea = do_swap ? b_q : a_q;
		eb = do_swap ? a_q : b_q;
		ela = do_swap ? lb : la_q;
		era = do_swap ? rb : ra_q;
		elb = do_swap ? la_q : lb;
		erb = do_swap ? ra_q : rb;
		// reversal trades left and right moves
		if (op_q != llmsr_pkg::OP_SWAP && rev_q) begin
			eop = (op_q == llmsr_pkg::OP_LEFT) ? llmsr_pkg::OP_RIGHT : llmsr_pkg::OP_LEFT;
		end else begin
			eop = op_q;
		end
		skip = ((eop == llmsr_pkg::OP_LEFT) && (era == eb))
			|| ((eop == llmsr_pkg::OP_RIGHT) && (erb == ea));
		ejl[0] = ela; ejr[0] = era;
		ejl[1] = ea;  ejr[1] = eb;
		ejl[2] = elb; ejr[2] = ea;
		ejl[3] = ea;  ejr[3] = erb;
		elast  = 2'd2;
		priority if (eop == llmsr_pkg::OP_LEFT) begin
			ejl[0] = ela; ejr[0] = era;
			ejl[1] = ea;  ejr[1] = eb;
			ejl[2] = elb; ejr[2] = ea;
		end else if (eop == llmsr_pkg::OP_RIGHT) begin
			ejl[0] = ela; ejr[0] = era;
			ejl[1] = eb;  ejr[1] = ea;
			ejl[2] = ea;  ejr[2] = erb;
		end else if (era == eb) begin
			// neighbours: exchange in place
			ejl[0] = ela; ejr[0] = eb;
			ejl[1] = eb;  ejr[1] = ea;
			ejl[2] = ea;  ejr[2] = erb;
		end else begin
			ejl[0] = ela; ejr[0] = eb;
			ejl[1] = eb;  ejr[1] = era;
			ejl[2] = elb; ejr[2] = ea;
			ejl[3] = ea;  ejr[3] = erb;
			elast  = 2'd3;
		end
	end

	// query walk: follow the next link straight from the ram output
	assign cur = (CW'(nxt_rdata) > CW'(MAX_BOXES)) ? '0 : nxt_rdata;

	// ram addressing
	always_comb begin
		nxt_raddr = a_q;
		prv_raddr = a_q;
		unique case (state_q)
			ST_RDB:  begin nxt_raddr = b_q; prv_raddr = b_q; end
			ST_Q0:   nxt_raddr = '0;
			ST_QW:   nxt_raddr = cur;
			default: begin nxt_raddr = a_q; prv_raddr = a_q; end
		endcase
	end

	always_comb begin
		nxt_we    = 1'b0;
		prv_we    = 1'b0;
		nxt_waddr = jl_q[k_q];
		nxt_wdata = jr_q[k_q];
		prv_waddr = jr_q[k_q];
		prv_wdata = jl_q[k_q];
		if (state_q == ST_WR) begin
			nxt_we = 1'b1;
			prv_we = 1'b1;
		end else if (state_q == ST_INIT) begin
			nxt_we    = 1'b1;
			prv_we    = 1'b1;
			nxt_waddr = iter_q;
			nxt_wdata = (iter_q == size_q) ? '0 : IW'(iter_q + 1'b1);
			prv_waddr = iter_q;
			prv_wdata = (iter_q == '0) ? size_q : IW'(iter_q - 1'b1);
		end
	end

	llmsr_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_nxt (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (nxt_rdata)
	);

	llmsr_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_prv (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (prv_raddr),
		.rdata (prv_rdata)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			box_count_q <= llmsr_pkg::BOX_W'(llmsr_pkg::BOX_COUNT_RST);
			rev_q       <= 1'b0;
			ready_q     <= 1'b0;
			size_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				box_count_q <= cfg_wdata;
			end
			// the query end refills the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_QFIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_op == llmsr_pkg::OP_INIT) begin
							size_q  <= IW'(n_init_w);
							rev_q   <= 1'b0;
							state_q <= ST_INIT;
						end else if (ready_q) begin
							if ((in_op == llmsr_pkg::OP_LEFT || in_op == llmsr_pkg::OP_RIGHT
								|| in_op == llmsr_pkg::OP_SWAP) && mv_ok) begin
								state_q <= ST_RDA;
							end else if (in_op == llmsr_pkg::OP_REVERSE) begin
								rev_q <= ~rev_q;
							end else if (in_op == llmsr_pkg::OP_QUERY) begin
								state_q <= ST_Q0;
							end
						end
					end
				end
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_EVAL;
				ST_EVAL: state_q <= skip ? ST_IDLE : ST_WR;
				ST_WR: begin
					if (k_q == jlast_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					if (iter_q == size_q) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_Q0: state_q <= ST_QW;
				ST_QW: begin
					if (iter_q == size_q) begin
						state_q <= ST_QFIN;
					end
				end
				ST_QFIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_op;
			a_q    <= IW'(in_a);
			b_q    <= IW'(in_b);
			iter_q <= '0;
		end
		if (state_q == ST_RDB) begin
			ra_q <= nxt_rdata;
			la_q <= prv_rdata;
		end
		if (state_q == ST_EVAL) begin
			for (int j = 0; j < 4; j++) begin
				jl_q[j] <= ejl[j];
				jr_q[j] <= ejr[j];
			end
			jlast_q <= elast;
			k_q     <= '0;
		end
		if (state_q == ST_WR) begin
			k_q <= k_q + 2'd1;
		end
		if (state_q == ST_INIT) begin
			iter_q <= iter_q + 1'b1;
		end
		if (state_q == ST_Q0) begin
			iter_q <= IW'(1);
			sum_q  <= '0;
			tri_q  <= '0;
		end
		if (state_q == ST_QW) begin
			// odd positions add their box; tri gathers n(n+1)/2
			if (iter_q[0]) begin
				sum_q <= sum_q + SW'(cur);
			end
			tri_q <= tri_q + SW'(iter_q);
			if (iter_q != size_q) begin
				iter_q <= iter_q + 1'b1;
			end
		end
		if (state_q == ST_QFIN && (!m_tvalid_q || m_tready)) begin
			res_q <= (rev_q && !size_q[0]) ? (tri_q - sum_q) : sum_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, res_q};

	// no table writes while waiting for an item
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !nxt_we && !prv_we)
		else $error("link table written while idle");

	// a result only appears at the end of a query walk
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_QFIN)
		else $error("result raised outside query end");

	// once built, the list stays built
	a_ready_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("list ready flag dropped");

	// moves and walks only run on a built list
	a_walk_needs_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDA || state_q == ST_Q0) |-> ready_q)
		else $error("list operation before init");

endmodule
